// ----- sv/ordered_key_value_table_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Ordered key/value table assertion macros
// Assertion wrappers shared by the table RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ORDERED_KEY_VALUE_TABLE_UNIT_DEFINES_SVH
`define ORDERED_KEY_VALUE_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// check an implication on every clock edge outside reset
`define OKVT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check that a condition never holds
`define OKVT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define OKVT_ASSERT(label, clk, rst_n, prop, msg)
`define OKVT_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ----- sv/okvt_pkg.sv -----
// ----------------------------------------------------------------------------
// Ordered key/value table package
// Sizes, command codes and shared structs of the table unit.
// ----------------------------------------------------------------------------
package okvt_pkg;

  localparam int unsigned CAPACITY   = 256;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 32;

  localparam int unsigned IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned OCC_W   = $clog2(CAPACITY + 1);
  localparam int unsigned ENTRY_W = KEY_BITS + VALUE_BITS;

  // port field widths
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned COUNT_W = 9;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UPSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

  typedef struct packed {
    logic               success;
    logic [FIELD_W-1:0] found_key;
    logic [FIELD_W-1:0] found_value;
    logic [COUNT_W-1:0] pair_count;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

endpackage

// ----- sv/okvt_req_if.sv -----
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one table command word.
// ----------------------------------------------------------------------------
interface okvt_req_if;
  logic                        valid;
  logic                        ready;
  logic [okvt_pkg::CMD_W-1:0]   command;
  logic [okvt_pkg::FIELD_W-1:0] req_key;
  logic [okvt_pkg::FIELD_W-1:0] req_value;
  logic [okvt_pkg::POS_W-1:0]   position;

  modport source (output valid, command, req_key, req_value, position, input ready);
  modport sink   (input valid, command, req_key, req_value, position, output ready);
endinterface

// ----- sv/okvt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one table result word.
// ----------------------------------------------------------------------------
interface okvt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         success;
  logic [okvt_pkg::FIELD_W-1:0] found_key;
  logic [okvt_pkg::FIELD_W-1:0] found_value;
  logic [okvt_pkg::COUNT_W-1:0] pair_count;
  logic                         is_empty;

  modport source (output valid, success, found_key, found_value, pair_count, is_empty,
                  input ready);
  modport sink   (input valid, success, found_key, found_value, pair_count, is_empty,
                  output ready);
endinterface

// ----- sv/ordered_key_value_table_unit.sv -----
// ----------------------------------------------------------------------------
// Ordered key/value table unit
// Insertion-ordered table of unique keys held in one pair RAM.
// ----------------------------------------------------------------------------
//  channel  dir  words
//  req_i    in   command, req_key, req_value, position
//  rsp_o    out  success, found_key, found_value, pair_count, is_empty
//
// A key search reads one entry at a time through the single RAM read port
// (states S_SRD, S_SCMP); an erase then moves each later pair down one place
// (states S_SHRD, S_SHWR). A new command is taken only while the sequencer
// is idle. Reset empties the table at once; no clearing pass. A result word
// waits in the output register while the next command runs; a stalled result
// holds.
// ----------------------------------------------------------------------------
`include "ordered_key_value_table_unit_defines.svh"

module ordered_key_value_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  okvt_req_if.sink    req_i,
  okvt_rsp_if.source  rsp_o
);

  okvt_pkg::mem_req_t                  mem_req;
  logic [okvt_pkg::ENTRY_W-1:0]        mem_rdata;
  logic                                res_valid;
  logic                                res_ready;
  okvt_pkg::result_t                   res;

  logic              rsp_valid_q, rsp_valid_d;
  okvt_pkg::result_t rsp_q, rsp_d;

  logic              req_fire;
  logic              res_move;

  okvt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .mem_o       (mem_req),
    .rdata_i     (mem_rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  okvt_ram #(
    .Width (okvt_pkg::ENTRY_W),
    .Depth (okvt_pkg::CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // output register: load when empty or being drained
  assign res_ready = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    if (res_valid && res_ready) begin
      rsp_valid_d = 1'b1;
      rsp_d       = res;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.success     = rsp_q.success;
  assign rsp_o.found_key   = rsp_q.found_key;
  assign rsp_o.found_value = rsp_q.found_value;
  assign rsp_o.pair_count  = rsp_q.pair_count;
  assign rsp_o.is_empty    = rsp_q.pair_count == '0;

  assign req_fire = req_i.valid && req_i.ready;
  assign res_move = res_valid && res_ready;

  `OKVT_ASSERT(a_busy_after_accept, clk_i, rst_ni, req_fire |=> !req_i.ready, "input not held")
  `OKVT_ASSERT(a_result_loaded, clk_i, rst_ni, res_move |=> rsp_valid_q, "result word lost")
  `OKVT_ASSERT_NEVER(a_idle_with_result, clk_i, rst_ni, req_i.ready && res_valid, "idle and done")

endmodule

// ----- sv/okvt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module okvt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/okvt_seq.sv -----
// ----------------------------------------------------------------------------
// Table sequencer
// Walks the pair RAM with one key comparator: search, append, shift-down, read by position.
// ----------------------------------------------------------------------------
module okvt_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  okvt_req_if.sink                      req_i,
  output okvt_pkg::mem_req_t            mem_o,
  input  logic [okvt_pkg::ENTRY_W-1:0]  rdata_i,
  output logic                          res_valid_o,
  output okvt_pkg::result_t             res_o,
  input  logic                          res_ready_i
);

  localparam int unsigned KW    = okvt_pkg::KEY_BITS;
  localparam int unsigned VW    = okvt_pkg::VALUE_BITS;
  localparam int unsigned IW    = okvt_pkg::IDX_W;
  localparam int unsigned OW    = okvt_pkg::OCC_W;
  localparam int unsigned PW    = okvt_pkg::POS_W;
  localparam int unsigned CMP_W = (OW > PW) ? OW : PW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRD  = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_MISS = 4'd3;
  localparam logic [3:0] S_SHRD = 4'd4;
  localparam logic [3:0] S_SHWR = 4'd5;
  localparam logic [3:0] S_IRD  = 4'd6;
  localparam logic [3:0] S_IDAT = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]                 state_q, state_d;
  logic [okvt_pkg::CMD_W-1:0] cmd_q, cmd_d;
  logic [KW-1:0]              key_q, key_d;
  logic [VW-1:0]              val_q, val_d;
  logic [PW-1:0]              pos_q, pos_d;
  logic [OW-1:0]              idx_q, idx_d;
  logic [OW-1:0]              occ_q, occ_d;
  logic                       ok_q, ok_d;
  logic [KW-1:0]              fkey_q, fkey_d;
  logic [VW-1:0]              fval_q, fval_d;

  logic [KW-1:0] rd_key;
  logic [VW-1:0] rd_val;
  logic [OW-1:0] idx_inc, idx_inc2;
  logic          pos_in_range, occ_full;

  assign rd_key       = rdata_i[okvt_pkg::ENTRY_W-1:VW];
  assign rd_val       = rdata_i[VW-1:0];
  assign idx_inc      = idx_q + OW'(1);
  assign idx_inc2     = idx_q + OW'(2);
  assign pos_in_range = CMP_W'(pos_q) < CMP_W'(occ_q);
  assign occ_full     = occ_q == OW'(okvt_pkg::CAPACITY);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    val_d       = val_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    occ_d       = occ_q;
    ok_d        = ok_q;
    fkey_d      = fkey_q;
    fval_d      = fval_q;
    mem_o.we    = 1'b0;
    mem_o.waddr = idx_q[IW-1:0];
    mem_o.wdata = {key_q, val_q};
    mem_o.raddr = idx_q[IW-1:0];
    req_i.ready = state_q == S_IDLE;
    res_valid_o = state_q == S_DONE;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          cmd_d  = req_i.command;
          key_d  = KW'(req_i.req_key);
          val_d  = VW'(req_i.req_value);
          pos_d  = req_i.position;
          idx_d  = '0;
          ok_d   = 1'b0;
          fkey_d = '0;
          fval_d = '0;
          case (req_i.command) inside
            okvt_pkg::CMD_INSERT, okvt_pkg::CMD_UPDATE, okvt_pkg::CMD_UPSERT,
            okvt_pkg::CMD_ERASE, okvt_pkg::CMD_LOOKUP: begin
              state_d = (occ_q == '0) ? S_MISS : S_SRD;
            end
            okvt_pkg::CMD_READ: state_d = S_IRD;
            default:            state_d = S_DONE;
          endcase
        end
      end
      S_SRD: begin
        state_d = S_SCMP;
      end
      S_SCMP: begin
        if (rd_key == key_q) begin
          state_d = S_DONE;
          case (cmd_q) inside
            okvt_pkg::CMD_UPDATE, okvt_pkg::CMD_UPSERT: begin
              mem_o.we = 1'b1;
              ok_d     = 1'b1;
            end
            okvt_pkg::CMD_ERASE: begin
              ok_d = 1'b1;
              // last pair goes without a shift
              if (idx_inc == occ_q) begin
                occ_d = occ_q - OW'(1);
              end else begin
                state_d = S_SHRD;
              end
            end
            okvt_pkg::CMD_LOOKUP: begin
              ok_d   = 1'b1;
              fkey_d = rd_key;
              fval_d = rd_val;
            end
            default: ok_d = 1'b0;
          endcase
        end else begin
          idx_d   = idx_inc;
          state_d = (idx_inc == occ_q) ? S_MISS : S_SRD;
        end
      end
      S_MISS: begin
        // append after the newest pair
        if ((cmd_q == okvt_pkg::CMD_INSERT || cmd_q == okvt_pkg::CMD_UPSERT) && !occ_full) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = occ_q[IW-1:0];
          ok_d        = 1'b1;
          occ_d       = occ_q + OW'(1);
        end
        state_d = S_DONE;
      end
      S_SHRD: begin
        mem_o.raddr = idx_inc[IW-1:0];
        state_d     = S_SHWR;
      end
      S_SHWR: begin
        mem_o.we    = 1'b1;
        mem_o.wdata = rdata_i;
        idx_d       = idx_inc;
        if (idx_inc2 == occ_q) begin
          occ_d   = occ_q - OW'(1);
          state_d = S_DONE;
        end else begin
          state_d = S_SHRD;
        end
      end
      S_IRD: begin
        mem_o.raddr = pos_q[IW-1:0];
        state_d     = pos_in_range ? S_IDAT : S_DONE;
      end
      S_IDAT: begin
        ok_d    = 1'b1;
        fkey_d  = rd_key;
        fval_d  = rd_val;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    key_q  <= key_d;
    val_q  <= val_d;
    pos_q  <= pos_d;
    idx_q  <= idx_d;
    ok_q   <= ok_d;
    fkey_q <= fkey_d;
    fval_q <= fval_d;
  end

  assign res_o.success     = ok_q;
  assign res_o.found_key   = okvt_pkg::FIELD_W'(fkey_q);
  assign res_o.found_value = okvt_pkg::FIELD_W'(fval_q);
  assign res_o.pair_count  = okvt_pkg::COUNT_W'(occ_q);

endmodule
